[rtl/assert_macros.svh]
// Assertion macros used by the top RTL file of the interpolator.
// Depends on nothing; files that check behavior include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge outside reset.
`define AWI_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define AWI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define AWI_ASSERT_ALWAYS(label, clk, rst, expr)
`define AWI_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

[rtl/awi_pkg.sv]
// Types and constants of the ADC-to-wiper interpolator.
// Depends on nothing; used by the front, blend and top modules of the block.
`default_nettype none
package awi_pkg;

   // Request kinds.
   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   // Field widths fixed by the interface.
   localparam int CH_W    = 2;
   localparam int IDX_W   = 6;
   localparam int DATA_W  = 8;
   localparam int FRAC_W  = 3;
   localparam int PROD_W  = 12;
   localparam int MAG_W   = 10;

   // Breakpoint spacing and its reciprocal as a fixed-point multiplier.
   localparam int STEP        = 5;
   localparam int RECIP       = 205;
   localparam int RECIP_SHIFT = 10;

   // Convert request after the sample has been split into index and offset.
   typedef struct packed {
      logic              valid;
      logic [CH_W-1:0]   channel;
      logic [IDX_W-1:0]  idx;
      logic [FRAC_W-1:0] frac;
   } lookup_type;

   // Convert request while the table points are being read out.
   typedef struct packed {
      logic              valid;
      logic [CH_W-1:0]   channel;
      logic [FRAC_W-1:0] frac;
   } blend_type;

endpackage
`default_nettype wire

[rtl/awi_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module awi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 204
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/awi_front.sv]
// Front stage: splits a sample into breakpoint index and offset (divide by five).
// Depends on awi_pkg.
`default_nettype none
module awi_front #(
   parameter int POINTS = 51
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       take,
   input  wire logic [awi_pkg::CH_W-1:0]   channel,
   input  wire logic [awi_pkg::DATA_W-1:0] sample,
   output awi_pkg::lookup_type             lookup
);

   localparam logic [awi_pkg::IDX_W-1:0] LAST = awi_pkg::IDX_W'(POINTS - 1);
   localparam int PRODW = awi_pkg::DATA_W + awi_pkg::RECIP_SHIFT;

   logic [PRODW-1:0]               recip_prod;
   logic [awi_pkg::IDX_W-1:0]      quot;
   logic [awi_pkg::DATA_W-1:0]     rem;
   awi_pkg::lookup_type            lookup_in;
   awi_pkg::lookup_type            lookup_ff;

   // Quotient by reciprocal multiply; exact for all 8-bit samples.
   always_comb begin
      recip_prod = PRODW'(sample) * PRODW'(awi_pkg::RECIP);
      quot       = recip_prod[awi_pkg::RECIP_SHIFT +: awi_pkg::IDX_W];
      rem        = sample - awi_pkg::DATA_W'(quot) * awi_pkg::DATA_W'(awi_pkg::STEP);
      lookup_in.valid   = take;
      lookup_in.channel = channel;
      // At or past the last breakpoint the last point is returned as is.
      if (quot >= LAST) begin
         lookup_in.idx  = LAST;
         lookup_in.frac = '0;
      end else begin
         lookup_in.idx  = quot;
         lookup_in.frac = rem[awi_pkg::FRAC_W-1:0];
      end
   end

   // Valid bit is control state and is reset; the rest is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff.valid <= 1'b0;
      end else begin
         lookup_ff.valid <= lookup_in.valid;
      end
      lookup_ff.channel <= lookup_in.channel;
      lookup_ff.idx     <= lookup_in.idx;
      lookup_ff.frac    <= lookup_in.frac;
   end

   assign lookup = lookup_ff;

endmodule
`default_nettype wire

[rtl/awi_blend.sv]
// Blend stages: offset times slope, truncating divide by five, add to base point.
// Depends on awi_pkg.
`default_nettype none
module awi_blend (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire awi_pkg::blend_type         blend,
   input  wire logic [awi_pkg::DATA_W-1:0] y0,
   input  wire logic [awi_pkg::DATA_W-1:0] y1,
   output logic                            out_valid,
   output logic      [awi_pkg::CH_W-1:0]   out_channel,
   output logic      [awi_pkg::DATA_W-1:0] out_wiper
);

   localparam int DIFF_W = awi_pkg::DATA_W + 1;
   localparam int QPW    = awi_pkg::MAG_W + awi_pkg::RECIP_SHIFT;

   logic signed [DIFF_W-1:0]         diff;
   logic signed [awi_pkg::PROD_W:0]  prod_full;
   logic signed [awi_pkg::PROD_W-1:0] prod_in;

   logic                             s3_valid_ff;
   logic [awi_pkg::CH_W-1:0]         s3_channel_ff;
   logic [awi_pkg::DATA_W-1:0]       s3_y0_ff;
   logic signed [awi_pkg::PROD_W-1:0] s3_prod_ff;

   logic [awi_pkg::PROD_W-1:0]       mag_full;
   logic [awi_pkg::MAG_W-1:0]        mag;
   logic [QPW-1:0]                   qprod;
   logic [awi_pkg::DATA_W-1:0]       qmag;
   logic [DIFF_W-1:0]                quot;
   logic [DIFF_W-1:0]                sum;

   logic                             out_valid_ff;
   logic [awi_pkg::CH_W-1:0]         out_channel_ff;
   logic [awi_pkg::DATA_W-1:0]       out_wiper_ff;

   // Slope times offset; an exact breakpoint contributes nothing.
   always_comb begin
      diff      = $signed({1'b0, y1}) - $signed({1'b0, y0});
      prod_full = $signed({1'b0, blend.frac}) * diff;
      if (blend.frac == '0) begin
         prod_in = '0;
      end else begin
         prod_in = prod_full[awi_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= blend.valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_channel_ff <= blend.channel;
      s3_y0_ff      <= y0;
      s3_prod_ff    <= prod_in;
   end

   // Divide the magnitude by five and restore the sign: truncation toward zero.
   always_comb begin
      mag_full = s3_prod_ff[awi_pkg::PROD_W-1] ? (~s3_prod_ff + 1'b1) : s3_prod_ff;
      mag      = mag_full[awi_pkg::MAG_W-1:0];
      qprod    = QPW'(mag) * QPW'(awi_pkg::RECIP);
      qmag     = qprod[awi_pkg::RECIP_SHIFT +: awi_pkg::DATA_W];
      quot     = s3_prod_ff[awi_pkg::PROD_W-1] ? (~{1'b0, qmag} + 1'b1) : {1'b0, qmag};
      sum      = {1'b0, s3_y0_ff} + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_channel_ff <= s3_channel_ff;
      out_wiper_ff   <= sum[awi_pkg::DATA_W-1:0];
   end

   assign out_valid   = out_valid_ff;
   assign out_channel = out_channel_ff;
   assign out_wiper   = out_wiper_ff;

endmodule
`default_nettype wire

[rtl/adc_to_wiper_interpolator_unit.sv]
// ADC-to-wiper interpolator: piecewise linear lookup over per-channel tables.
// A convert request passes the front register, the table read, the blend product register and the output register.
// Throughput: one request per cycle; busy is high only during reset.
// Reset clears all valid bits; table contents are undefined until written.
// A table write lands in both table copies at its accept edge.
// Depends on awi_pkg, awi_ram, awi_front, awi_blend and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module adc_to_wiper_interpolator_unit #(
   parameter int CHANNELS = 4,
   parameter int POINTS   = 51
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_type,
   input  wire logic [awi_pkg::CH_W-1:0]   req_channel,
   input  wire logic [awi_pkg::IDX_W-1:0]  req_point_index,
   input  wire logic [awi_pkg::DATA_W-1:0] req_point_value,
   input  wire logic [awi_pkg::DATA_W-1:0] req_sample,
   output logic                            rsp_valid,
   output logic      [awi_pkg::CH_W-1:0]   rsp_out_channel,
   output logic      [awi_pkg::DATA_W-1:0] rsp_wiper_value
);

   localparam int DEPTH  = CHANNELS * POINTS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                       take;
   logic                       chan_ok;
   logic                       wr_en;
   logic                       conv_take;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr0;
   logic [ADDR_W-1:0]          rd_addr1;
   logic [awi_pkg::DATA_W-1:0] y0;
   logic [awi_pkg::DATA_W-1:0] y1;
   awi_pkg::lookup_type        lookup;
   awi_pkg::blend_type         blend_in;
   awi_pkg::blend_type         blend_ff;

   // Request decode; requests on a channel beyond the table set are dropped.
   assign busy      = reset;
   assign take      = start && !busy;
   assign chan_ok   = 32'(req_channel) < CHANNELS;
   assign conv_take = take && chan_ok && (req_type == awi_pkg::REQ_CONVERT);
   assign wr_en     = take && chan_ok && (req_type == awi_pkg::REQ_WRITE)
                      && (32'(req_point_index) < POINTS);
   assign wr_addr   = ADDR_W'(ADDR_W'(req_channel) * ADDR_W'(POINTS))
                      + ADDR_W'(req_point_index);

   awi_front #(
      .POINTS (POINTS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (conv_take),
      .channel (req_channel),
      .sample  (req_sample),
      .lookup  (lookup)
   );

   // Table addresses of the point at the breakpoint and the next one; a zero offset reads the first twice.
   assign rd_addr0 = ADDR_W'(ADDR_W'(lookup.channel) * ADDR_W'(POINTS))
                     + ADDR_W'(lookup.idx);
   assign rd_addr1 = (lookup.frac != '0) ? (rd_addr0 + 1'b1) : rd_addr0;

   // Two copies of the table give two reads per cycle.
   awi_ram #(
      .WIDTH (awi_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_point_value),
      .rd_addr (rd_addr0),
      .rd_data (y0)
   );

   awi_ram #(
      .WIDTH (awi_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_point_value),
      .rd_addr (rd_addr1),
      .rd_data (y1)
   );

   // Request info travels alongside the table read.
   always_comb begin
      blend_in.valid   = lookup.valid;
      blend_in.channel = lookup.channel;
      blend_in.frac    = lookup.frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff.valid <= 1'b0;
      end else begin
         blend_ff.valid <= blend_in.valid;
      end
      blend_ff.channel <= blend_in.channel;
      blend_ff.frac    <= blend_in.frac;
   end

   awi_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .blend       (blend_ff),
      .y0          (y0),
      .y1          (y1),
      .out_valid   (rsp_valid),
      .out_channel (rsp_out_channel),
      .out_wiper   (rsp_wiper_value)
   );

   // Each accepted convert request yields exactly one response.
   `AWI_ASSERT_ALWAYS(a_rsp_matches_convert, clock, reset, rsp_valid == $past(conv_take, 4))
   // The response carries the channel of the request it answers.
   `AWI_ASSERT_IMPL(a_rsp_channel, clock, reset, rsp_valid, rsp_out_channel == $past(req_channel, 4))
   // The offset inside a segment stays below the breakpoint spacing.
   `AWI_ASSERT_IMPL(a_frac_range, clock, reset, lookup.valid, 32'(lookup.frac) < awi_pkg::STEP)

endmodule
`default_nettype wire

[tb/sv/tb_adc_to_wiper_interpolator_unit.sv]
// Self-checking testbench for the ADC-to-wiper interpolator unit.
// It predicts each wiper value from its own copy of the point tables and compares responses.
// Depends on awi_pkg and adc_to_wiper_interpolator_unit.
`default_nettype none
module tb_adc_to_wiper_interpolator_unit;

   localparam int   CH_W        = awi_pkg::CH_W;
   localparam int   IDX_W       = awi_pkg::IDX_W;
   localparam int   DATA_W      = awi_pkg::DATA_W;
   localparam logic REQ_WRITE   = awi_pkg::REQ_WRITE;
   localparam logic REQ_CONVERT = awi_pkg::REQ_CONVERT;

   localparam int NUM_CHANNELS = 4;
   localparam int NUM_POINTS   = 51;
   localparam int BREAK_STEP   = 5;
   localparam int DUT_LATENCY  = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1320;

   // One expected response of a convert request.
   typedef struct {
      logic [CH_W-1:0]   channel;
      logic [DATA_W-1:0] wiper;
   } wiper_expect_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_type;
   logic [CH_W-1:0]     req_channel;
   logic [IDX_W-1:0]    req_point_index;
   logic [DATA_W-1:0]   req_point_value;
   logic [DATA_W-1:0]   req_sample;
   logic                rsp_valid;
   logic [CH_W-1:0]     rsp_out_channel;
   logic [DATA_W-1:0]   rsp_wiper_value;

   // Shadow copy of the point tables and the responses still owed by the block.
   logic [DATA_W-1:0]   wiper_table [NUM_CHANNELS][NUM_POINTS];
   wiper_expect_type    pending_wipers [$];
   int unsigned         error_count;
   int unsigned         cycle_count;
   bit                  idle_enable;

   adc_to_wiper_interpolator_unit #(
      .CHANNELS(NUM_CHANNELS),
      .POINTS  (NUM_POINTS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_channel    (req_channel),
      .req_point_index(req_point_index),
      .req_point_value(req_point_value),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_out_channel(rsp_out_channel),
      .rsp_wiper_value(rsp_wiper_value)
   );

   // Free-running clock with a period of 12 units.
   always #6 clock = ~clock;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Linear interpolation between the two neighboring table points, clamped to the last point at the top.
   function automatic logic [DATA_W-1:0] interp_wiper(input logic [CH_W-1:0] ch,
                                                      input logic [DATA_W-1:0] smp);
      int seg;
      int off;
      int lo;
      int hi;
      int delta;
      seg = int'(smp) / BREAK_STEP;
      off = int'(smp) % BREAK_STEP;
      if (seg >= NUM_POINTS - 1)
         return wiper_table[ch][NUM_POINTS-1];
      lo = int'(wiper_table[ch][seg]);
      if (off == 0)
         return lo[DATA_W-1:0];
      hi = int'(wiper_table[ch][seg+1]);
      // Integer division in SystemVerilog truncates toward zero, as required for falling slopes.
      delta = (off * (hi - lo)) / BREAK_STEP;
      return DATA_W'(lo + delta);
   endfunction

   // Mostly back-to-back requests, sometimes short gaps, rarely a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!idle_enable)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Samples lean toward breakpoints, the bottom segments, the top segment and the clamped range.
   function automatic logic [DATA_W-1:0] pick_sample();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 2)
         return DATA_W'($urandom_range(245, 255));
      else if (roll == 2)
         return DATA_W'(BREAK_STEP * $urandom_range(0, NUM_POINTS - 1));
      else if (roll == 3)
         return DATA_W'($urandom_range(0, 9));
      return DATA_W'($urandom);
   endfunction

   // Point values lean toward the extremes so that steep slopes show up often.
   function automatic logic [DATA_W-1:0] pick_point_value();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      else if (roll == 1)
         return '1;
      return DATA_W'($urandom);
   endfunction

   // Drive one request at the falling edge, wait for acceptance, then update the prediction.
   task automatic send_request(input logic                rtype,
                               input logic [CH_W-1:0]     ch,
                               input logic [IDX_W-1:0]    idx,
                               input logic [DATA_W-1:0]   val,
                               input logic [DATA_W-1:0]   smp);
      int unsigned      gap;
      wiper_expect_type next_wiper;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         start           <= 1'b0;
         req_type        <= 1'($urandom);
         req_channel     <= CH_W'($urandom);
         req_point_index <= IDX_W'($urandom);
         req_point_value <= DATA_W'($urandom);
         req_sample      <= DATA_W'($urandom);
      end
      @(negedge clock);
      start           <= 1'b1;
      req_type        <= rtype;
      req_channel     <= ch;
      req_point_index <= idx;
      req_point_value <= val;
      req_sample      <= smp;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      // The request was accepted at this edge.
      if (rtype == REQ_WRITE) begin
         if (idx < NUM_POINTS)
            wiper_table[ch][idx] = val;
      end else begin
         next_wiper.channel = ch;
         next_wiper.wiper   = interp_wiper(ch, smp);
         pending_wipers.push_back(next_wiper);
      end
   endtask

   // Stop sending and wait until every conversion has come back and the pipeline is quiet.
   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_wipers.size() != 0)
         @(posedge clock);
      repeat (DUT_LATENCY) @(posedge clock);
   endtask

   // Breakpoints, truncation on rising and falling slopes, and the clamp at the top.
   task automatic test_interpolation_edges();
      idle_enable = 1'b1;
      send_request(REQ_WRITE, 2'd0, 6'd0,  8'd254, DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd1,  8'd0,   DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd2,  8'd3,   DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd49, 8'd0,   DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd50, 8'd255, DATA_W'($urandom));
      // Junk goes on the index and value ports, which a conversion ignores.
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd0);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd1);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd4);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd5);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd7);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd9);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd249);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd250);
      send_request(REQ_CONVERT, 2'd0, IDX_W'($urandom), DATA_W'($urandom), 8'd255);
   endtask

   // Writes past the last point must not land in the next channel's table.
   task automatic test_ignored_writes();
      wait_until_drained();
      send_request(REQ_WRITE, 2'd1, 6'd0,  8'd17,  DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd1, 6'd1,  8'd40,  DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd1, 6'd12, 8'd99,  DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd1, 6'd13, 8'd120, DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd51, 8'h5a,  DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd0, 6'd63, 8'ha5,  DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd3, 6'd50, 8'd0,   DATA_W'($urandom));
      send_request(REQ_WRITE, 2'd3, 6'd63, 8'd255, DATA_W'($urandom));
      send_request(REQ_CONVERT, 2'd1, IDX_W'($urandom), DATA_W'($urandom), 8'd0);
      send_request(REQ_CONVERT, 2'd1, IDX_W'($urandom), DATA_W'($urandom), 8'd60);
      send_request(REQ_CONVERT, 2'd3, IDX_W'($urandom), DATA_W'($urandom), 8'd255);
   endtask

   // Load every point of every channel so that any sample may be converted afterwards.
   task automatic test_table_fill();
      wait_until_drained();
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         for (int idx = 0; idx < NUM_POINTS; idx++)
            send_request(REQ_WRITE, CH_W'(ch), IDX_W'(idx), pick_point_value(),
                         DATA_W'($urandom));
      end
   endtask

   // Bursts of conversions, with table rewrites between them while the block is quiet.
   task automatic test_random_traffic(input int unsigned item_budget);
      int unsigned sent;
      int unsigned burst;
      logic [IDX_W-1:0] idx;
      sent = 0;
      while (sent < item_budget) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_until_drained();
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               if ($urandom_range(0, 7) == 0)
                  idx = IDX_W'($urandom_range(NUM_POINTS, 63));
               else
                  idx = IDX_W'($urandom_range(0, NUM_POINTS - 1));
               send_request(REQ_WRITE, CH_W'($urandom), idx, pick_point_value(),
                            DATA_W'($urandom));
               sent++;
            end
         end
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            send_request(REQ_CONVERT, CH_W'($urandom), IDX_W'($urandom),
                         DATA_W'($urandom), pick_sample());
            sent++;
         end
      end
   endtask

   // Compare each response strobe with the oldest expected wiper value.
   always @(posedge clock) begin : check_responses
      wiper_expect_type head;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_wipers.size() == 0) begin
            report_mismatch($sformatf("response with nothing expected: ch=%0d wiper=%0d",
                                      rsp_out_channel, rsp_wiper_value));
         end else begin
            head = pending_wipers.pop_front();
            if (rsp_out_channel !== head.channel)
               report_mismatch($sformatf("out_channel %0d, expected %0d",
                                         rsp_out_channel, head.channel));
            if (rsp_wiper_value !== head.wiper)
               report_mismatch($sformatf("wiper_value %0d, expected %0d on channel %0d",
                                         rsp_wiper_value, head.wiper, head.channel));
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Reset once, run the tests in turn, then drain and give the verdict.
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      start           = 1'b0;
      req_type        = REQ_WRITE;
      req_channel     = '0;
      req_point_index = '0;
      req_point_value = '0;
      req_sample      = '0;
      error_count     = 0;
      cycle_count     = 0;
      idle_enable     = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_interpolation_edges();
      test_ignored_writes();
      test_table_fill();
      test_random_traffic(RANDOM_ITEMS);

      wait_until_drained();
      repeat (DUT_LATENCY + 4) @(posedge clock);
      if (pending_wipers.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_wipers.size()));
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire
